[design/hptc_pkg.sv]
// Shared constants and helper functions for the environmental compensation unit.
// Depends on nothing; used by humidity_pressure_temp_compensation_unit.
package hptc_pkg;

   localparam int unsigned RawPressW = 20;
   localparam int unsigned RawTempW  = 20;
   localparam int unsigned RawHumW   = 16;
   localparam int unsigned IdW       = 8;
   localparam int unsigned ReqDataW  = 64;
   localparam int unsigned RspDataW  = 88;
   localparam int unsigned CsrIdxW   = 3;
   localparam int unsigned CsrDataW  = 64;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] REG_TEMP       = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_PRESS_LOW  = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_PRESS_HIGH = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_MIXED      = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_HUM        = 3'd4;

   localparam logic [IdW-1:0]       CHIP_ID_OK = 8'h60;
   localparam logic [RawTempW-1:0]  SKIP_20    = 20'h80000;
   localparam logic [RawHumW-1:0]   SKIP_16    = 16'h8000;
   localparam logic [31:0]          HUM_MAX    = 32'd419430400;

   // Arithmetic right shift of a 32-bit pattern.
   function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
      return $unsigned($signed(v) >>> n);
   endfunction

   // Arithmetic right shift of a 64-bit pattern.
   function automatic logic [63:0] asr64(input logic [63:0] v, input logic [5:0] n);
      return $unsigned($signed(v) >>> n);
   endfunction

   // Sign extension of a 16-bit trim value to 64 bits.
   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   // Widen a 32-bit value for the shared multiplier (low 32 product bits are exact).
   function automatic logic [63:0] z32(input logic [31:0] v);
      return {32'd0, v};
   endfunction

endpackage

[design/humidity_pressure_temp_compensation_unit.sv]
// Top level of the environmental compensation unit: sequencer, bit-serial multiplier
// and bit-serial divider. Depends on hptc_pkg.
//
// Usage: one raw measurement enters on the req_ stream (pressure, temperature,
// humidity and the chip identity byte in req_tdata). One compensated item leaves
// on the rsp_ stream. Trim coefficients are written beforehand through the csr_
// port, one register per write, while no item is in flight.
// A single shared multiplier retires one bit of its multiplier operand per cycle,
// and the signed 64-bit pressure divide is bit-serial as well. An item with all
// three readings present runs 21 multiplies, one divide and 28 program steps
// between acceptance and rsp_tvalid. Skipped readings shorten this; a wrong
// identity byte, or all three readings skipped, gives a result in the cycle
// straight after acceptance.
// One item is worked on at a time: req_tready is high only while the unit is idle.
// The result is held in the output register until rsp_tready takes it; a stall
// holds the unit with its result and no new item is taken.
// Reset clears the trim registers, the kept fine temperature and the sequencer.
module humidity_pressure_temp_compensation_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40], chip_identity[63:56]
   input  logic [hptc_pkg::ReqDataW-1:0]     req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // temperature_centi[31:0], pressure_q8[63:32], humidity_q10[80:64], sensor_ok[81]
   output logic [hptc_pkg::RspDataW-1:0]     rsp_tdata,
   input  logic                              csr_we,
   input  logic [hptc_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [hptc_pkg::CsrDataW-1:0]     csr_wdata
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // Program steps: temperature, pressure, humidity.
   localparam logic [4:0] PC_T0  = 5'd0;
   localparam logic [4:0] PC_T1  = 5'd1;
   localparam logic [4:0] PC_T2  = 5'd2;
   localparam logic [4:0] PC_T3  = 5'd3;
   localparam logic [4:0] PC_P0  = 5'd4;
   localparam logic [4:0] PC_P1  = 5'd5;
   localparam logic [4:0] PC_P2  = 5'd6;
   localparam logic [4:0] PC_P3  = 5'd7;
   localparam logic [4:0] PC_P4  = 5'd8;
   localparam logic [4:0] PC_P5  = 5'd9;
   localparam logic [4:0] PC_P6  = 5'd10;
   localparam logic [4:0] PC_P7  = 5'd11;
   localparam logic [4:0] PC_P8  = 5'd12;
   localparam logic [4:0] PC_P9  = 5'd13;
   localparam logic [4:0] PC_P10 = 5'd14;
   localparam logic [4:0] PC_P11 = 5'd15;
   localparam logic [4:0] PC_P12 = 5'd16;
   localparam logic [4:0] PC_P13 = 5'd17;
   localparam logic [4:0] PC_H0  = 5'd18;
   localparam logic [4:0] PC_H1  = 5'd19;
   localparam logic [4:0] PC_H2  = 5'd20;
   localparam logic [4:0] PC_H3  = 5'd21;
   localparam logic [4:0] PC_H4  = 5'd22;
   localparam logic [4:0] PC_H5  = 5'd23;
   localparam logic [4:0] PC_H6  = 5'd24;
   localparam logic [4:0] PC_H7  = 5'd25;
   localparam logic [4:0] PC_H8  = 5'd26;
   localparam logic [4:0] PC_H9  = 5'd27;

   // Control state.
   logic [2:0]  st_ff, st_in;
   logic [4:0]  pc_ff, pc_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] fine_ff, fine_in;

   // Trim registers.
   logic [47:0] tc_ff;
   logic [63:0] pcl_ff, pch_ff;
   logic [47:0] mc_ff;
   logic [31:0] hc_ff;

   // Item and working registers.
   logic [hptc_pkg::RawPressW-1:0] rp_ff, rp_in;
   logic [hptc_pkg::RawTempW-1:0]  rt_ff, rt_in;
   logic [hptc_pkg::RawHumW-1:0]   rh_ff, rh_in;
   logic        ok_ff, ok_in;
   logic [63:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [31:0] t_ff, t_in, p_ff, p_in;
   logic [16:0] h_ff, h_in;

   // Multiplier and divider registers.
   logic [63:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in, acc_ff, acc_in;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic        neg_ff, neg_in;

   // Trim fields.
   logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;

   assign t1 = {48'd0, tc_ff[15:0]};
   assign t2 = hptc_pkg::sx16(tc_ff[31:16]);
   assign t3 = hptc_pkg::sx16(tc_ff[47:32]);
   assign p1 = {48'd0, pcl_ff[15:0]};
   assign p2 = hptc_pkg::sx16(pcl_ff[31:16]);
   assign p3 = hptc_pkg::sx16(pcl_ff[47:32]);
   assign p4 = hptc_pkg::sx16(pcl_ff[63:48]);
   assign p5 = hptc_pkg::sx16(pch_ff[15:0]);
   assign p6 = hptc_pkg::sx16(pch_ff[31:16]);
   assign p7 = hptc_pkg::sx16(pch_ff[47:32]);
   assign p8 = hptc_pkg::sx16(pch_ff[63:48]);
   assign p9 = hptc_pkg::sx16(mc_ff[15:0]);
   assign h1 = {24'd0, mc_ff[23:16]};
   assign h2 = {{16{mc_ff[39]}}, mc_ff[39:24]};
   assign h3 = {24'd0, mc_ff[47:40]};
   assign h4 = {{20{hc_ff[11]}}, hc_ff[11:0]};
   assign h5 = {{20{hc_ff[23]}}, hc_ff[23:12]};
   assign h6 = {{24{hc_ff[31]}}, hc_ff[31:24]};

   // Handshake and result.
   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = (st_ff == ST_OUT);
   assign rsp_tdata  = {6'd0, ok_ff, h_ff, p_ff, t_ff};

   // Sequencer, program steps and the serial arithmetic units.
   always_comb begin
      logic        mul_go;
      logic [63:0] mx, my;
      logic        go_press, go_hum;
      logic [4:0]  after_t, after_p;
      logic [2:0]  st_after_t, st_after_p;
      logic [31:0] v32, w32;
      logic [63:0] v64, w64;
      logic [64:0] r2;

      st_in = st_ff;   pc_in = pc_ff;   cnt_in = cnt_ff; fine_in = fine_ff;
      rp_in = rp_ff;   rt_in = rt_ff;   rh_in = rh_ff;   ok_in = ok_ff;
      a_in = a_ff;     b_in = b_ff;     c_in = c_ff;     d_in = d_ff;
      t_in = t_ff;     p_in = p_ff;     h_in = h_ff;
      mul_a_in = mul_a_ff; mul_b_in = mul_b_ff; acc_in = acc_ff;
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; neg_in = neg_ff;
      mul_go = 1'b0;   mx = 64'd0;      my = 64'd0;
      v32 = 32'd0;     w32 = 32'd0;     v64 = 64'd0;     w64 = 64'd0;
      r2 = 65'd0;

      // Section order: temperature, then pressure, then humidity, each if present.
      go_press = (rp_ff != hptc_pkg::SKIP_20);
      go_hum   = (rh_ff != hptc_pkg::SKIP_16);
      after_p    = PC_H0;
      st_after_p = go_hum ? ST_EXEC : ST_OUT;
      after_t    = go_press ? PC_P0 : PC_H0;
      st_after_t = (go_press || go_hum) ? ST_EXEC : ST_OUT;

      case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rp_in = req_tdata[19:0];
               rt_in = req_tdata[39:20];
               rh_in = req_tdata[55:40];
               ok_in = (req_tdata[63:56] == hptc_pkg::CHIP_ID_OK);
               t_in = 32'd0; p_in = 32'd0; h_in = 17'd0;
               if (req_tdata[63:56] != hptc_pkg::CHIP_ID_OK) begin
                  st_in = ST_OUT;
               end else if (req_tdata[39:20] != hptc_pkg::SKIP_20) begin
                  st_in = ST_EXEC; pc_in = PC_T0;
               end else if (req_tdata[19:0] != hptc_pkg::SKIP_20) begin
                  st_in = ST_EXEC; pc_in = PC_P0;
               end else if (req_tdata[55:40] != hptc_pkg::SKIP_16) begin
                  st_in = ST_EXEC; pc_in = PC_H0;
               end else begin
                  st_in = ST_OUT;
               end
            end
         end

         ST_EXEC: begin
            pc_in = pc_ff + 5'd1;
            case (pc_ff)
               // Temperature.
               PC_T0: begin
                  v32 = ({12'd0, rt_ff} >> 3) - (t1[31:0] << 1);
                  mul_go = 1'b1; mx = hptc_pkg::z32(v32); my = t2;
               end
               PC_T1: begin
                  a_in = hptc_pkg::z32(hptc_pkg::asr32(acc_ff[31:0], 5'd11));
                  v32 = ({12'd0, rt_ff} >> 4) - t1[31:0];
                  mul_go = 1'b1; mx = hptc_pkg::z32(v32); my = hptc_pkg::z32(v32);
               end
               PC_T2: begin
                  mul_go = 1'b1;
                  mx = hptc_pkg::z32(hptc_pkg::asr32(acc_ff[31:0], 5'd12)); my = t3;
               end
               PC_T3: begin
                  v32 = a_ff[31:0] + hptc_pkg::asr32(acc_ff[31:0], 5'd14);
                  fine_in = v32;
                  t_in = hptc_pkg::asr32((v32 << 2) + v32 + 32'd128, 5'd8);
                  pc_in = after_t; st_in = st_after_t;
               end
               // Pressure.
               PC_P0: begin
                  v64 = {{32{fine_ff[31]}}, fine_ff} - 64'd128000;
                  a_in = v64;
                  mul_go = 1'b1; mx = v64; my = v64;
               end
               PC_P1: begin
                  c_in = acc_ff;
                  mul_go = 1'b1; mx = acc_ff; my = p6;
               end
               PC_P2: begin
                  b_in = acc_ff;
                  mul_go = 1'b1; mx = a_ff; my = p5;
               end
               PC_P3: begin
                  b_in = b_ff + (acc_ff << 17) + (p4 << 35);
                  mul_go = 1'b1; mx = c_ff; my = p3;
               end
               PC_P4: begin
                  c_in = hptc_pkg::asr64(acc_ff, 6'd8);
                  mul_go = 1'b1; mx = a_ff; my = p2;
               end
               PC_P5: begin
                  c_in = c_ff + (acc_ff << 12);
               end
               PC_P6: begin
                  mul_go = 1'b1; mx = (64'd1 << 47) + c_ff; my = p1;
               end
               PC_P7: begin
                  v64 = hptc_pkg::asr64(acc_ff, 6'd33);
                  a_in = v64;
                  if (v64 == 64'd0) begin
                     pc_in = after_p; st_in = st_after_p;
                  end else begin
                     w64 = ((64'd1048576 - {44'd0, rp_ff}) << 31) - b_ff;
                     c_in = w64;
                     mul_go = 1'b1; mx = w64; my = 64'd3125;
                  end
               end
               PC_P8: begin
                  // Signed divide on magnitudes; the sign is applied afterwards.
                  neg_in = acc_ff[63] ^ a_ff[63];
                  quo_in = acc_ff[63] ? (64'd0 - acc_ff) : acc_ff;
                  den_in = a_ff[63] ? (64'd0 - a_ff) : a_ff;
                  rem_in = 64'd0; cnt_in = 6'd0;
                  st_in = ST_DIV; pc_in = pc_ff;
               end
               PC_P9: begin
                  v64 = neg_ff ? (64'd0 - quo_ff) : quo_ff;
                  c_in = v64;
                  mul_go = 1'b1; mx = p9; my = hptc_pkg::asr64(v64, 6'd13);
               end
               PC_P10: begin
                  mul_go = 1'b1; mx = acc_ff; my = hptc_pkg::asr64(c_ff, 6'd13);
               end
               PC_P11: begin
                  b_in = hptc_pkg::asr64(acc_ff, 6'd25);
                  mul_go = 1'b1; mx = p8; my = c_ff;
               end
               PC_P12: begin
                  b_in = b_ff + hptc_pkg::asr64(acc_ff, 6'd19);
               end
               PC_P13: begin
                  v64 = hptc_pkg::asr64(c_ff + b_ff, 6'd8) + (p7 << 4);
                  p_in = v64[31:0];
                  pc_in = after_p; st_in = st_after_p;
               end
               // Humidity.
               PC_H0: begin
                  v32 = fine_ff - 32'd76800;
                  a_in = hptc_pkg::z32(v32);
                  mul_go = 1'b1; mx = hptc_pkg::z32(h5); my = hptc_pkg::z32(v32);
               end
               PC_H1: begin
                  v32 = ({16'd0, rh_ff} << 14) - (h4 << 20) - acc_ff[31:0];
                  b_in = hptc_pkg::z32(v32);
               end
               PC_H2: begin
                  b_in = hptc_pkg::z32(hptc_pkg::asr32(b_ff[31:0] + 32'd16384, 5'd15));
                  mul_go = 1'b1; mx = a_ff; my = hptc_pkg::z32(h6);
               end
               PC_H3: begin
                  c_in = hptc_pkg::z32(hptc_pkg::asr32(acc_ff[31:0], 5'd10));
                  mul_go = 1'b1; mx = a_ff; my = hptc_pkg::z32(h3);
               end
               PC_H4: begin
                  v32 = hptc_pkg::asr32(acc_ff[31:0], 5'd11) + 32'd32768;
                  mul_go = 1'b1; mx = c_ff; my = hptc_pkg::z32(v32);
               end
               PC_H5: begin
                  v32 = hptc_pkg::asr32(acc_ff[31:0], 5'd10) + 32'd2097152;
                  mul_go = 1'b1; mx = hptc_pkg::z32(v32); my = hptc_pkg::z32(h2);
               end
               PC_H6: begin
                  v32 = hptc_pkg::asr32(acc_ff[31:0] + 32'd8192, 5'd14);
                  c_in = hptc_pkg::z32(v32);
                  mul_go = 1'b1; mx = b_ff; my = hptc_pkg::z32(v32);
               end
               PC_H7: begin
                  d_in = acc_ff;
                  v32 = hptc_pkg::asr32(acc_ff[31:0], 5'd15);
                  mul_go = 1'b1; mx = hptc_pkg::z32(v32); my = hptc_pkg::z32(v32);
               end
               PC_H8: begin
                  v32 = hptc_pkg::asr32(acc_ff[31:0], 5'd7);
                  mul_go = 1'b1; mx = hptc_pkg::z32(v32); my = hptc_pkg::z32(h1);
               end
               PC_H9: begin
                  // Clamp to the valid range before dropping the fraction bits.
                  v32 = d_ff[31:0] - hptc_pkg::asr32(acc_ff[31:0], 5'd4);
                  if (v32[31]) begin
                     w32 = 32'd0;
                  end else if (v32 > hptc_pkg::HUM_MAX) begin
                     w32 = hptc_pkg::HUM_MAX;
                  end else begin
                     w32 = v32;
                  end
                  h_in = w32[28:12];
                  st_in = ST_OUT;
               end
               default: begin
                  st_in = ST_OUT;
               end
            endcase
            if (mul_go) begin
               mul_a_in = mx; mul_b_in = my; acc_in = 64'd0; cnt_in = 6'd0;
               st_in = ST_MUL; pc_in = pc_ff;
            end
         end

         // Shift-and-add multiply, one multiplier bit per cycle, product mod 2^64.
         ST_MUL: begin
            acc_in   = acc_ff + (mul_b_ff[0] ? mul_a_ff : 64'd0);
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               st_in = ST_EXEC; pc_in = pc_ff + 5'd1;
            end
         end

         // Restoring divide, one quotient bit per cycle.
         ST_DIV: begin
            r2 = {rem_ff, quo_ff[63]};
            if (r2 >= {1'b0, den_ff}) begin
               w64 = 64'(r2 - {1'b0, den_ff});
               rem_in = w64;
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = r2[63:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               st_in = ST_EXEC; pc_in = pc_ff + 5'd1;
            end
         end

         ST_OUT: begin
            if (rsp_tready) begin
               st_in = ST_IDLE;
            end
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Control state and trim registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         pc_ff   <= PC_T0;
         cnt_ff  <= 6'd0;
         fine_ff <= 32'd0;
         ok_ff   <= 1'b0;
         tc_ff   <= 48'd0;
         pcl_ff  <= 64'd0;
         pch_ff  <= 64'd0;
         mc_ff   <= 48'd0;
         hc_ff   <= 32'd0;
      end else begin
         st_ff   <= st_in;
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
         fine_ff <= fine_in;
         ok_ff   <= ok_in;
         if (csr_we) begin
            case (csr_index)
               hptc_pkg::REG_TEMP:       tc_ff  <= csr_wdata[47:0];
               hptc_pkg::REG_PRESS_LOW:  pcl_ff <= csr_wdata;
               hptc_pkg::REG_PRESS_HIGH: pch_ff <= csr_wdata;
               hptc_pkg::REG_MIXED:      mc_ff  <= csr_wdata[47:0];
               hptc_pkg::REG_HUM:        hc_ff  <= csr_wdata[31:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      rp_ff <= rp_in;  rt_ff <= rt_in;  rh_ff <= rh_in;
      a_ff  <= a_in;   b_ff  <= b_in;   c_ff  <= c_in;   d_ff <= d_in;
      t_ff  <= t_in;   p_ff  <= p_in;   h_ff  <= h_in;
      mul_a_ff <= mul_a_in; mul_b_ff <= mul_b_in; acc_ff <= acc_in;
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; neg_ff <= neg_in;
   end

   // A result with a wrong identity carries only zeros.
   a_bad_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !ok_ff) |-> (t_ff == 32'd0 && p_ff == 32'd0 && h_ff == 17'd0))
      else $error("result for a wrong identity is not zero");

   // Humidity never leaves its clamped range.
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (h_ff <= 17'd102400))
      else $error("humidity out of range");

   // An accepted item starts work at once.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (st_ff != ST_IDLE))
      else $error("unit idle after accepting an item");

   // The serial units only ever hand back to the sequencer.
   a_serial_return: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == ST_MUL || st_ff == ST_DIV) && cnt_ff == 6'd63) |=> (st_ff == ST_EXEC))
      else $error("serial unit did not return to the sequencer");

endmodule

[tb/hptc_checker.sv]
// Checker for the environmental compensation unit: watches the req_, rsp_ and csr_ ports,
// predicts each compensated item and compares it field by field.
// Depends on hptc_pkg for widths and register indexes.
module hptc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [hptc_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [hptc_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                          csr_we,
   input  logic [hptc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [hptc_pkg::CsrDataW-1:0] csr_wdata,
   output int                            mismatches,
   output int                            pending
);

   typedef struct packed {
      logic        ok;
      logic [16:0] hum;
      logic [31:0] press;
      logic [31:0] temp;
   } comp_item_type;

   // Local copy of the trim registers and the kept fine temperature.
   logic [63:0] trim_temp, trim_press_lo, trim_press_hi, trim_mixed, trim_hum;
   logic [31:0] fine_t;
   comp_item_type awaited[$];

   function automatic logic [31:0] sar32(logic [31:0] v, int n);
      return $unsigned($signed(v) >>> n);
   endfunction

   function automatic logic [63:0] sar64(logic [63:0] v, int n);
      return $unsigned($signed(v) >>> n);
   endfunction

   // Temperature; updates the kept fine temperature.
   function automatic logic [31:0] calc_temp(logic [31:0] raw);
      logic [31:0] t1, t2, t3, v1, v2, d;
      t1 = {16'd0, trim_temp[15:0]};
      t2 = {{16{trim_temp[31]}}, trim_temp[31:16]};
      t3 = {{16{trim_temp[47]}}, trim_temp[47:32]};
      v1 = sar32(((raw >> 3) - (t1 << 1)) * t2, 11);
      d = (raw >> 4) - t1;
      v2 = sar32(sar32(d * d, 12) * t3, 14);
      fine_t = v1 + v2;
      return sar32(fine_t * 32'd5 + 32'd128, 8);
   endfunction

   function automatic logic [63:0] sx(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [31:0] calc_press(logic [31:0] raw);
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q, w1, w2, un, ud;
      logic neg;
      p1 = {48'd0, trim_press_lo[15:0]};
      p2 = sx(trim_press_lo[31:16]);
      p3 = sx(trim_press_lo[47:32]);
      p4 = sx(trim_press_lo[63:48]);
      p5 = sx(trim_press_hi[15:0]);
      p6 = sx(trim_press_hi[31:16]);
      p7 = sx(trim_press_hi[47:32]);
      p8 = sx(trim_press_hi[63:48]);
      p9 = sx(trim_mixed[15:0]);
      a = {{32{fine_t[31]}}, fine_t} - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = sar64(a * a * p3, 8) + ((a * p2) << 12);
      a = sar64(((64'd1 << 47) + a) * p1, 33);
      if (a == 64'd0) return 32'd0;
      p = 64'd1048576 - {32'd0, raw};
      p = ((p << 31) - b) * 64'd3125;
      // Signed divide, truncating toward zero.
      neg = p[63] ^ a[63];
      un = p[63] ? -p : p;
      ud = a[63] ? -a : a;
      p = un / ud;
      if (neg) p = -p;
      q = sar64(p, 13);
      w1 = sar64(p9 * q * q, 25);
      w2 = sar64(p8 * p, 19);
      p = sar64(p + w1 + w2, 8) + (p7 << 4);
      return p[31:0];
   endfunction

   function automatic logic [16:0] calc_hum(logic [31:0] raw);
      logic [31:0] h1, h2, h3, h4, h5, h6, t, c1, c2, c3, c4, c5, h;
      h1 = {24'd0, trim_mixed[23:16]};
      h2 = {{16{trim_mixed[39]}}, trim_mixed[39:24]};
      h3 = {24'd0, trim_mixed[47:40]};
      h4 = {{20{trim_hum[11]}}, trim_hum[11:0]};
      h5 = {{20{trim_hum[23]}}, trim_hum[23:12]};
      h6 = {{24{trim_hum[31]}}, trim_hum[31:24]};
      t = fine_t - 32'd76800;
      c1 = (raw << 14) - (h4 << 20) - h5 * t;
      c1 = sar32(c1 + 32'd16384, 15);
      c2 = sar32(t * h6, 10);
      c3 = sar32(t * h3, 11) + 32'd32768;
      c4 = sar32((sar32(c2 * c3, 10) + 32'd2097152) * h2 + 32'd8192, 14);
      h = c1 * c4;
      c5 = sar32(sar32(h, 15) * sar32(h, 15), 7);
      h = h - sar32(c5 * h1, 4);
      // Clamp to the valid humidity range.
      if (h[31]) h = 32'd0;
      if (h > hptc_pkg::HUM_MAX) h = hptc_pkg::HUM_MAX;
      h = h >> 12;
      return h[16:0];
   endfunction

   function automatic comp_item_type predict_comp(logic [63:0] d);
      comp_item_type r;
      logic [19:0] rp, rt;
      logic [15:0] rh;
      r = '0;
      rp = d[19:0];
      rt = d[39:20];
      rh = d[55:40];
      if (d[63:56] == hptc_pkg::CHIP_ID_OK) begin
         r.ok = 1'b1;
         if (rt != hptc_pkg::SKIP_20) r.temp = calc_temp({12'd0, rt});
         if (rp != hptc_pkg::SKIP_20) r.press = calc_press({12'd0, rp});
         if (rh != hptc_pkg::SKIP_16) r.hum = calc_hum({16'd0, rh});
      end
      return r;
   endfunction

   assign pending = awaited.size();

   // Follow register writes, predict accepted items and check results.
   always @(posedge clock) begin
      comp_item_type got, want;
      if (reset) begin
         trim_temp <= '0;
         trim_press_lo <= '0;
         trim_press_hi <= '0;
         trim_mixed <= '0;
         trim_hum <= '0;
         fine_t = '0;
         mismatches <= 0;
         awaited.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               hptc_pkg::REG_TEMP: begin
                  trim_temp <= {16'd0, csr_wdata[47:0]};
               end
               hptc_pkg::REG_PRESS_LOW: begin
                  trim_press_lo <= csr_wdata;
               end
               hptc_pkg::REG_PRESS_HIGH: begin
                  trim_press_hi <= csr_wdata;
               end
               hptc_pkg::REG_MIXED: begin
                  trim_mixed <= {16'd0, csr_wdata[47:0]};
               end
               hptc_pkg::REG_HUM: begin
                  trim_hum <= {32'd0, csr_wdata[31:0]};
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) awaited.push_back(predict_comp(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[81:0];
            if (awaited.size() == 0) begin
               if (mismatches < 10) $display("unexpected result item %h", got);
               mismatches <= mismatches + 1;
            end else begin
               want = awaited.pop_front();
               if (got != want) begin
                  if (mismatches < 10)
                     $display("mismatch: temp %h/%h press %h/%h hum %h/%h ok %b/%b (exp/act)",
                              want.temp, got.temp, want.press, got.press,
                              want.hum, got.hum, want.ok, got.ok);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end
endmodule

[tb/tb_humidity_pressure_temp_compensation_unit.sv]
// Top of the compensation unit testbench: clock, reset, register phases and item stimulus.
// Depends on hptc_pkg, hptc_checker and humidity_pressure_temp_compensation_unit.
module tb_humidity_pressure_temp_compensation_unit;

   logic                          clock, reset;
   logic                          req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [hptc_pkg::ReqDataW-1:0] req_tdata;
   logic [hptc_pkg::RspDataW-1:0] rsp_tdata;
   logic                          csr_we;
   logic [hptc_pkg::CsrIdxW-1:0]  csr_index;
   logic [hptc_pkg::CsrDataW-1:0] csr_wdata;
   int                            mismatches, pending;
   int                            sent_items, taken_items;

   humidity_pressure_temp_compensation_unit dut (.*);

   hptc_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit well beyond the slowest correct run.
   initial begin
      #16000000;
      $display("humidity_pressure_temp_compensation_unit test failed");
      $finish;
   end

   // Count result items taken.
   always @(posedge clock) begin
      if (reset) taken_items <= 0;
      else if (rsp_tvalid && rsp_tready) taken_items <= taken_items + 1;
   end

   // Result side: random stall before each item.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = $urandom_range(0, 8);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   task automatic send_meas(input logic [19:0] rp, input logic [19:0] rt,
                            input logic [15:0] rh, input logic [7:0] id);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {id, rh, rt, rp};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sent_items++;
      @(negedge clock);
   endtask

   // Drops valid, then lets every outstanding item come back.
   task automatic drain_all();
      req_tvalid <= 1'b0;
      while (taken_items != sent_items) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // One register write, after which csr_we is dropped again.
   task automatic write_reg(input logic [hptc_pkg::CsrIdxW-1:0] idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_trims(input logic [63:0] t, input logic [63:0] pl,
                             input logic [63:0] ph, input logic [63:0] m,
                             input logic [63:0] h);
      write_reg(hptc_pkg::REG_TEMP, t);
      write_reg(hptc_pkg::REG_PRESS_LOW, pl);
      write_reg(hptc_pkg::REG_PRESS_HIGH, ph);
      write_reg(hptc_pkg::REG_MIXED, m);
      write_reg(hptc_pkg::REG_HUM, h);
   endtask

   // Random measurement, mostly valid identity with occasional skips.
   task automatic send_random();
      logic [19:0] rp, rt;
      logic [15:0] rh;
      logic [7:0]  id;
      rp = 20'($urandom());
      rt = 20'($urandom());
      rh = 16'($urandom());
      id = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : hptc_pkg::CHIP_ID_OK;
      if ($urandom_range(0, 2) == 0) rt = 20'($urandom_range(380000, 600000));
      if ($urandom_range(0, 2) == 0) rp = 20'($urandom_range(250000, 450000));
      if ($urandom_range(0, 19) == 0) rt = hptc_pkg::SKIP_20;
      if ($urandom_range(0, 19) == 0) rp = hptc_pkg::SKIP_20;
      if ($urandom_range(0, 19) == 0) rh = hptc_pkg::SKIP_16;
      send_meas(rp, rt, rh, id);
   endtask

   initial begin
      logic [63:0] typ_t, typ_pl, typ_ph, typ_m, typ_h;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      sent_items = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Typical factory trim values.
      typ_t  = 64'({16'hFC18, 16'd26435, 16'd27504});
      typ_pl = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
      typ_ph = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
      typ_m  = 64'({8'd0, 16'd362, 8'd75, 16'd6000});
      typ_h  = 64'({8'd30, 12'd0, 12'd324});

      // All trims zero: pressure divisor is zero.
      send_meas(20'd300000, 20'd500000, 16'd30000, hptc_pkg::CHIP_ID_OK);
      send_meas(20'd0, 20'd0, 16'd0, hptc_pkg::CHIP_ID_OK);
      drain_all();

      load_trims(typ_t, typ_pl, typ_ph, typ_m, typ_h);
      write_reg(3'd5, '1);
      write_reg(3'd7, 64'h0123456789ABCDEF);
      send_meas(20'd415148, 20'd519888, 16'd30000, hptc_pkg::CHIP_ID_OK);
      send_meas(20'd0, 20'd0, 16'd0, hptc_pkg::CHIP_ID_OK);
      send_meas(20'hFFFFF, 20'hFFFFF, 16'hFFFF, hptc_pkg::CHIP_ID_OK);
      send_meas(20'd415148, hptc_pkg::SKIP_20, 16'd30000, hptc_pkg::CHIP_ID_OK);
      send_meas(hptc_pkg::SKIP_20, 20'd519888, 16'd30000, hptc_pkg::CHIP_ID_OK);
      send_meas(20'd415148, 20'd519888, hptc_pkg::SKIP_16, hptc_pkg::CHIP_ID_OK);
      send_meas(hptc_pkg::SKIP_20, hptc_pkg::SKIP_20, hptc_pkg::SKIP_16,
                hptc_pkg::CHIP_ID_OK);
      send_meas(20'd415148, 20'd519888, 16'd30000, 8'h61);
      send_meas(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 8'hFF);
      send_meas(20'd0, 20'd0, 16'd0, 8'h00);
      send_meas(20'd415148, hptc_pkg::SKIP_20, 16'd30000, hptc_pkg::CHIP_ID_OK);
      send_meas(20'h7FFFF, 20'h80001, 16'h7FFF, hptc_pkg::CHIP_ID_OK);
      send_meas(20'd300000, 20'd400000, 16'd65000, hptc_pkg::CHIP_ID_OK);
      send_meas(20'd300000, 20'd400000, 16'd1, hptc_pkg::CHIP_ID_OK);
      // Hold off until every result has come back.
      drain_all();

      // All trim bits set.
      load_trims('1, '1, '1, '1, '1);
      send_meas(20'd415148, 20'd519888, 16'd30000, hptc_pkg::CHIP_ID_OK);
      send_meas(20'hFFFFF, 20'hFFFFF, 16'hFFFF, hptc_pkg::CHIP_ID_OK);
      drain_all();

      // Random phases under several trim settings.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin
               load_trims(typ_t, typ_pl, typ_ph, typ_m, typ_h);
            end
            1: begin
               load_trims({$urandom(), $urandom()}, {$urandom(), $urandom()},
                          {$urandom(), $urandom()}, {$urandom(), $urandom()},
                          {$urandom(), $urandom()});
            end
            2: begin
               load_trims(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                          64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                          64'h5555_5555_5555_5555);
            end
            default: begin
               load_trims(typ_t ^ 64'($urandom_range(0, 255)), typ_pl, typ_ph,
                          typ_m ^ {$urandom(), $urandom()}, {$urandom(), $urandom()});
            end
         endcase
         for (int n = 0; n < 141; n++) send_random();
         drain_all();
      end

      repeat (40) @(negedge clock);
      $display("Sent %0d measurement items over eight random trim phases plus directed", sent_items);
      $display("cases for skips, identity errors, extreme readings and zero divisors.");
      if (mismatches == 0 && pending == 0) begin
         $display("humidity_pressure_temp_compensation_unit test passed");
      end else begin
         $display("humidity_pressure_temp_compensation_unit test failed");
      end
      $finish;
   end
endmodule
